>>> rtl/cwpg_pkg.sv
`default_nettype none

package cwpg_pkg;

    // Sizing of the window and the node history.
    localparam int MAX_HALF      = 4;
    localparam int NODE_BITS     = 32;
    localparam int HIST_DEPTH    = 2 * MAX_HALF + 1;
    localparam int ADDR_BITS     = $clog2(HIST_DEPTH);
    localparam int OFF_BITS      = $clog2(MAX_HALF + 1);
    localparam int COUNT_BITS    = 4;
    localparam int COUNT_MAX     = 15;
    localparam int WIN_BITS      = 4;
    localparam int WIN_RESET     = 5;

    // Register port sizing.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Register indexes, taken from the word address bit of paddr.
    localparam logic REG_WIN_WIDTH = 1'b0;

    typedef logic [NODE_BITS-1:0]  t_node;
    typedef logic [ADDR_BITS-1:0]  t_addr;
    typedef logic [OFF_BITS-1:0]   t_off;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [WIN_BITS-1:0]   t_win;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CENTER,
        S_PAIR
    } t_state;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic  shift;
        logic  load_center;
        logic  emit;
        t_addr rd_addr;
        logic  run_last;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic slot_free;
    } t_dp_status;

    // Half-width of the context window, limited to MAX_HALF.
    function automatic t_off half_width(input t_win ws);
        logic [WIN_BITS:0] sum;
        sum = {1'b0, ws} + (WIN_BITS + 1)'(1);
        sum = sum >> 1;
        if (sum > (WIN_BITS + 1)'(MAX_HALF)) begin
            return OFF_BITS'(MAX_HALF);
        end
        return sum[OFF_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/cwpg_ifs.sv
`default_nettype none

// Channel carrying one walk node per beat.
interface cwpg_node_if;
    import cwpg_pkg::*;

    logic  valid;
    logic  ready;
    t_node node_id;
    logic  seq_end;

    modport source (output valid, output node_id, output seq_end, input ready);
    modport sink   (input valid, input node_id, input seq_end, output ready);
endinterface

// Channel carrying one (center, context) pair per beat.
interface cwpg_pair_if;
    import cwpg_pkg::*;

    logic  valid;
    logic  ready;
    t_node center_node;
    t_node context_node;
    logic  run_last;

    modport source (output valid, output center_node, output context_node,
                    output run_last, input ready);
    modport sink   (input valid, input center_node, input context_node,
                    input run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/cwpg_cfg.sv
`default_nettype none

module cwpg_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwpg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [cwpg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [cwpg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output cwpg_pkg::t_win                     o_win_width
);
    import cwpg_pkg::*;

    t_win r_win_width;
    logic w_reg_index;
    logic w_write;

    // Word index of the addressed register.
    assign w_reg_index = paddr[2];
    assign w_write     = psel && penable && pwrite;

    // Window width register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_width <= WIN_BITS'(WIN_RESET);
        end else if (w_write && (w_reg_index == REG_WIN_WIDTH)) begin
            r_win_width <= pwdata[WIN_BITS-1:0];
        end
    end

    // Read data and a port that never waits.
    always_comb begin
        prdata = '0;
        if (w_reg_index == REG_WIN_WIDTH) begin
            prdata = {{(APB_DATA_BITS - WIN_BITS){1'b0}}, r_win_width};
        end
    end

    assign pready      = 1'b1;
    assign o_win_width = r_win_width;

endmodule

`default_nettype wire

>>> rtl/cwpg_dp.sv
`default_nettype none

module cwpg_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cwpg_pkg::t_dp_cmd      i_cmd,
    input  cwpg_pkg::t_node        i_node_id,
    output cwpg_pkg::t_dp_status   o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output cwpg_pkg::t_node        o_center_node,
    output cwpg_pkg::t_node        o_context_node,
    output logic                   o_run_last
);
    import cwpg_pkg::*;

    t_node r_hist [HIST_DEPTH];
    t_node r_center;
    t_node w_rd_data;
    logic  r_out_valid;
    t_node r_out_center;
    t_node r_out_ctx;
    logic  r_out_run_last;
    logic  w_slot_free;

    // Node history: entry 0 is the newest node.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_hist[0] <= i_node_id;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    // Single read port into the history.
    assign w_rd_data = r_hist[i_cmd.rd_addr];

    // Center node of the pairs being generated.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_center) begin
            r_center <= w_rd_data;
        end
    end

    // The output register takes a new beat when empty or being drained.
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_center   <= r_center;
            r_out_ctx      <= w_rd_data;
            r_out_run_last <= i_cmd.run_last;
        end
    end

    assign o_status.slot_free = w_slot_free;
    assign o_out_valid        = r_out_valid;
    assign o_center_node      = r_out_center;
    assign o_context_node     = r_out_ctx;
    assign o_run_last         = r_out_run_last;

endmodule

`default_nettype wire

>>> rtl/cwpg_ctrl.sv
`default_nettype none

module cwpg_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_seq_end,
    output logic                   o_in_ready,
    input  cwpg_pkg::t_win         i_win_width,
    input  cwpg_pkg::t_dp_status   i_status,
    output cwpg_pkg::t_dp_cmd      o_cmd
);
    import cwpg_pkg::*;

    t_state r_state, n_state;
    t_count r_count, n_count;
    t_count r_pos,   n_pos;
    logic   r_last,  n_last;
    t_off   r_half,  n_half;
    t_off   r_o,     n_o;
    t_addr  r_k,     n_k;

    logic   w_in_fire;
    t_off   w_half_now;
    t_off   w_o_start;
    logic   w_has_center;
    t_count w_diff;
    t_off   w_left;
    t_addr  w_k_start;
    logic   w_has_pairs;
    logic   w_last_center;
    logic   w_k_done;
    t_addr  w_k_next;

    assign w_in_fire  = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    // First center of an accepted node: on a sequence end, all pending
    // centers are flushed starting from the oldest one.
    assign w_half_now   = half_width(i_win_width);
    assign w_has_center = i_seq_end || (r_count >= COUNT_BITS'(w_half_now));
    always_comb begin
        w_o_start = w_half_now;
        if (i_seq_end && (r_count < COUNT_BITS'(w_half_now))) begin
            w_o_start = r_count[OFF_BITS-1:0];
        end
    end

    // Earlier neighbors of the current center, limited by the half-width.
    assign w_diff = r_pos - COUNT_BITS'(r_o);
    assign w_left = (w_diff > COUNT_BITS'(r_half)) ? r_half : w_diff[OFF_BITS-1:0];

    // Contexts walk from the oldest earlier neighbor down to the newest node,
    // stepping over the center itself.
    assign w_has_pairs = (r_o != '0) || (w_left != '0);
    assign w_k_start   = (w_left != '0) ? (ADDR_BITS'(r_o) + ADDR_BITS'(w_left))
                                        : (ADDR_BITS'(r_o) - ADDR_BITS'(1));
    assign w_k_done    = (r_k == '0) || ((r_k == ADDR_BITS'(1)) && (r_o == '0));
    assign w_k_next    = ((r_k - ADDR_BITS'(1)) == ADDR_BITS'(r_o)) ? (r_k - ADDR_BITS'(2))
                                                                   : (r_k - ADDR_BITS'(1));
    assign w_last_center = !r_last || (r_o == '0);

    // Next state and loop counters.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_last  = r_last;
        n_half  = r_half;
        n_o     = r_o;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_pos  = r_count;
                    n_last = i_seq_end;
                    n_half = w_half_now;
                    n_o    = w_o_start;
                    if (i_seq_end) begin
                        n_count = '0;
                    end else if (r_count != COUNT_BITS'(COUNT_MAX)) begin
                        n_count = r_count + COUNT_BITS'(1);
                    end
                    n_state = w_has_center ? S_CENTER : S_IDLE;
                end
            end
            S_CENTER: begin
                if (w_has_pairs) begin
                    n_k     = w_k_start;
                    n_state = S_PAIR;
                end else if (w_last_center) begin
                    n_state = S_IDLE;
                end else begin
                    n_o = r_o - OFF_BITS'(1);
                end
            end
            S_PAIR: begin
                if (i_status.slot_free) begin
                    if (w_k_done) begin
                        if (w_last_center) begin
                            n_state = S_IDLE;
                        end else begin
                            n_o     = r_o - OFF_BITS'(1);
                            n_state = S_CENTER;
                        end
                    end else begin
                        n_k = w_k_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd             = '0;
        o_cmd.shift       = w_in_fire;
        o_cmd.rd_addr     = r_k;
        case (r_state)
            S_CENTER: begin
                o_cmd.load_center = 1'b1;
                o_cmd.rd_addr     = ADDR_BITS'(r_o);
            end
            S_PAIR: begin
                o_cmd.emit     = i_status.slot_free;
                o_cmd.run_last = w_k_done && w_last_center;
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_last <= n_last;
        r_half <= n_half;
        r_o    <= n_o;
        r_k    <= n_k;
    end

    // The context index never lands on the center while pairs are emitted.
    a_k_not_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR) |-> (r_k != ADDR_BITS'(r_o)))
        else $error("context index points at the center");

    // History reads stay inside the stored window.
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.load_center) |-> (o_cmd.rd_addr < ADDR_BITS'(HIST_DEPTH)))
        else $error("history read beyond its depth");

    // The last pair of a node returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.run_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after the last pair");

    // A sequence end restarts the position count.
    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_seq_end) |=> (r_count == '0))
        else $error("position count not cleared at sequence end");

endmodule

`default_nettype wire

>>> rtl/context_window_pair_generator.sv
// Skip-gram pair generator for walk sequences. Each input beat carries one node
// id and a flag on the last node of its sequence; each output beat carries one
// (center, context) pair, with run_last set on the final pair caused by that
// input. With half-width H = min((W+1)/2, 4) for window width W, a center is
// released once H later nodes have arrived or when its sequence ends; its
// earlier neighbors come first, oldest first, then its later neighbors, nearest
// first. The window width register sits at byte address 0 of the register port
// (reset value 5); the user must write it only while the block is idle, and the
// block itself does not enforce this. The block works on one node at a time: a
// node that releases no center is done once accepted; otherwise, for each
// released center, it fetches the center and then emits its pairs one by one,
// since the node history has a single read port. A sequence end can flush up to
// five centers. A stalled output holds the pair emission.
`default_nettype none

module context_window_pair_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cwpg_node_if.sink                          i_node,
    cwpg_pair_if.source                        o_pair,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwpg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [cwpg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [cwpg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import cwpg_pkg::*;

    t_win       w_win_width;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // Configuration register.
    cwpg_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_win_width (w_win_width)
    );

    // Sequencer over centers and contexts.
    cwpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_node.valid),
        .i_seq_end   (i_node.seq_end),
        .o_in_ready  (w_in_ready),
        .i_win_width (w_win_width),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // History and output register.
    cwpg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_node_id      (i_node.node_id),
        .o_status       (w_status),
        .o_out_valid    (o_pair.valid),
        .i_out_ready    (o_pair.ready),
        .o_center_node  (o_pair.center_node),
        .o_context_node (o_pair.context_node),
        .o_run_last     (o_pair.run_last)
    );

    assign i_node.ready = w_in_ready;

endmodule

`default_nettype wire

>>> tb/cwpg_pair_checker.sv
`default_nettype none

// Watches the node and pair channels, predicts the pairs of every accepted node
// and compares each pair beat with the oldest prediction still waiting.
module cwpg_pair_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cwpg_node_if                               node_ch,
    cwpg_pair_if                               pair_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cwpg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [cwpg_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic                               pready,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cwpg_pkg::*;

    typedef struct packed {
        t_node center;
        t_node ctx_node;
        logic  last;
    } t_pair_beat;

    // Shadow copy of the block state: newest node in entry 0.
    t_node      walk_hist [HIST_DEPTH];
    t_count     walk_pos;
    t_win       win_size;
    t_pair_beat pair_queue [$];
    int         fail_count = 0;

    function automatic int unsigned context_half(input t_win ws);
        int unsigned h;
        h = (int'(ws) + 1) / 2;
        return (h > MAX_HALF) ? MAX_HALF : h;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Queues the pairs of the center at offset o when the newest node sits at
    // position p: earlier neighbors oldest first, then later ones nearest first.
    task automatic push_center(input int unsigned o, input int unsigned p,
                               input int unsigned h);
        int unsigned left;
        t_pair_beat  beat;
        left = p - o;
        if (left > h) begin
            left = h;
        end
        beat.center = walk_hist[o];
        beat.last   = 1'b0;
        for (int unsigned k = o + left; k > o; k--) begin
            beat.ctx_node = walk_hist[k];
            pair_queue    = {pair_queue, beat};
        end
        for (int unsigned k = o; k > 0; k--) begin
            beat.ctx_node = walk_hist[k-1];
            pair_queue    = {pair_queue, beat};
        end
    endtask

    // Updates the shadow state with one node beat and queues its pairs.
    task automatic predict_node(input t_node id, input logic last);
        int unsigned h;
        int unsigned p;
        int unsigned first;
        h     = context_half(win_size);
        p     = walk_pos;
        first = pair_queue.size();
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            walk_hist[i] = walk_hist[i-1];
        end
        walk_hist[0] = id;
        if (last) begin
            // Flush every pending center of the sequence, oldest first.
            for (int o = int'((p < h) ? p : h); o >= 0; o--) begin
                push_center(o, p, h);
            end
            walk_pos = '0;
        end else begin
            if (p >= h) begin
                push_center(h, p, h);
            end
            if (walk_pos != t_count'(COUNT_MAX)) begin
                walk_pos++;
            end
        end
        if (pair_queue.size() > first) begin
            pair_queue[pair_queue.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_pair_beat want;
        t_pair_beat got;
        if (!i_rst_n) begin
            walk_pos = '0;
            win_size = t_win'(WIN_RESET);
            pair_queue.delete();
        end else begin
            // Register writes only ever land while the block is idle.
            if (psel && penable && pwrite && pready && paddr[2] == REG_WIN_WIDTH) begin
                win_size = pwdata[WIN_BITS-1:0];
            end
            if (node_ch.valid && node_ch.ready) begin
                predict_node(node_ch.node_id, node_ch.seq_end);
            end
            if (pair_ch.valid && pair_ch.ready) begin
                got.center   = pair_ch.center_node;
                got.ctx_node = pair_ch.context_node;
                got.last     = pair_ch.run_last;
                if (pair_queue.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected pair beat: center %h context %h run_last %b",
                        got.center, got.ctx_node, got.last));
                end else begin
                    want = pair_queue.pop_front();
                    if (want.center !== got.center || want.ctx_node !== got.ctx_node ||
                        want.last !== got.last) begin
                        note_failure($sformatf(
                            "pair mismatch: expected %h/%h/%b, got %h/%h/%b",
                            want.center, want.ctx_node, want.last,
                            got.center, got.ctx_node, got.last));
                    end
                end
            end
        end
        o_pending    <= pair_queue.size();
        o_fail_count <= fail_count;
    end

endmodule

`default_nettype wire

>>> tb/context_window_pair_generator_test.sv
`default_nettype none

module context_window_pair_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cwpg_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending;
    bit                       idling = 1'b1;

    cwpg_node_if node_ch ();
    cwpg_pair_if pair_ch ();

    always #5 i_clk = ~i_clk;

    context_window_pair_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_node  (node_ch),
        .o_pair  (pair_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cwpg_pair_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .node_ch      (node_ch),
        .pair_ch      (pair_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The pair receiver stalls now and then unless idling is switched off.
    always @(posedge i_clk) begin
        pair_ch.ready <= !idling || ($urandom_range(99) >= 13);
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic t_node rand_node();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return t_node'($urandom());
        endcase
    endfunction

    // Offers one node beat, with an occasional gap in front of it.
    task automatic send_node(input t_node id, input logic last);
        while (idling && $urandom_range(99) < 13) begin
            node_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        node_ch.valid   <= 1'b1;
        node_ch.node_id <= id;
        node_ch.seq_end <= last;
        @(posedge i_clk);
        while (!node_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_walk(input int len, input bit closed);
        for (int i = 0; i < len; i++) begin
            send_node(rand_node(), closed && i == len - 1);
        end
    endtask

    // Holds the node channel quiet until every predicted pair has come out.
    task automatic settle();
        node_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    // Writes the window width once the block is idle; a node whose centers have no
    // pairs may still be in flight, hence the short pause.
    task automatic write_window(input t_win ws);
        settle();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_BITS'({REG_WIN_WIDTH, 2'b00});
        pwdata  <= APB_DATA_BITS'(ws);
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        node_ch.valid   = 1'b0;
        node_ch.node_id = '0;
        node_ch.seq_end = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window: a lone node releases its center with no pairs.
        send_node(32'h1234_5678, 1'b1);
        // Reset window with extreme node values over a short walk.
        send_node(32'h0000_0000, 1'b0);
        send_node(32'hFFFF_FFFF, 1'b0);
        send_node(32'h5555_5555, 1'b0);
        send_node(32'hAAAA_AAAA, 1'b0);
        send_node(32'h0000_0001, 1'b0);
        send_node(32'h8000_0000, 1'b1);
        // Zero window: no pairs at all.
        write_window(t_win'(0));
        send_walk(3, 1'b1);
        // Oversized window saturates to the largest half-width.
        write_window(t_win'(15));
        send_walk(8, 1'b1);
        // Window changed in the middle of a walk.
        write_window(t_win'(2));
        send_walk(3, 1'b0);
        write_window(t_win'(6));
        send_walk(3, 1'b1);

        // Random walks over several window settings; one phase without idling.
        for (int ph = 0; ph < 9; ph++) begin
            write_window((ph == 0) ? t_win'(8) :
                         (ph == 1) ? t_win'(0) : t_win'($urandom_range(8)));
            idling = (ph != 3);
            sent   = 0;
            while (sent < 33) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 22)
                                               : $urandom_range(1, 10);
                send_walk(len, $urandom_range(7) != 0);
                sent += len;
            end
        end
        idling = 1'b1;

        settle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/cwpg_pkg.sv
rtl/cwpg_ifs.sv
rtl/cwpg_cfg.sv
rtl/cwpg_dp.sv
rtl/cwpg_ctrl.sv
rtl/context_window_pair_generator.sv
tb/cwpg_pair_checker.sv
tb/context_window_pair_generator_test.sv
